// ===== design/adip_pkg.sv =====
`timescale 1ns / 1ps

package adip_pkg;

  // Parse phase of the number currently being collected.
  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_SIGN   = 2'd1,
    PH_DIGITS = 2'd2
  } phase_e;

  localparam logic [7:0]  CHAR_PLUS   = 8'h2B;
  localparam logic [7:0]  CHAR_MINUS  = 8'h2D;

  localparam int unsigned MAG_W       = 34;
  localparam int unsigned DCNT_W      = 4;
  localparam int unsigned LEN_W       = 8;

  localparam logic [DCNT_W-1:0] MAX_DIGITS  = DCNT_W'(10);
  localparam logic [DCNT_W-1:0] OVER_DIGITS = DCNT_W'(11);
  localparam logic [MAG_W-1:0]  MAX_MAG     = MAG_W'(64'd2147483647);
  localparam logic [31:0]       NA_VALUE    = 32'h8000_0000;
  localparam logic [LEN_W-1:0]  LEN_MAX     = {LEN_W{1'b1}};

  // Accumulator state carried from one byte to the next.
  typedef struct packed {
    logic                is_negative;
    logic                saw_leading_zero;
    logic [DCNT_W-1:0]   digit_count;
    logic [MAG_W-1:0]    magnitude;
    logic [LEN_W-1:0]    consumed_count;
  } num_t;

  localparam num_t NUM_CLEAR = '{
    is_negative:      1'b0,
    saw_leading_zero: 1'b0,
    digit_count:      '0,
    magnitude:        '0,
    consumed_count:   '0
  };

endpackage

// ===== design/ascii_decimal_int32_parser_core.sv =====
`timescale 1ns / 1ps

// Channel  | Direction | Handshake                 | Payload
// ---------+-----------+---------------------------+-------------------------------------
// input    | in        | in_valid_i / in_stall_o   | char_in_i, starts_field_i
// result   | out       | out_valid_o / out_stall_i | value_out_o, status_out_o, length_out_o
//
// One byte is taken per cycle; the accumulator update (a times-ten add and a
// range compare) sits between the state registers and the result register.
// A result appears on the outputs in the cycle after the byte that ends the number.
// in_stall_o is high only while a result is held in the output register and the
// result side is stalling; otherwise a transfer can happen in every cycle.
// rst_ni clears the parse phase, the accumulator and the output valid flag.

module ascii_decimal_int32_parser_core
  import adip_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  char_in_i,
  input  logic        starts_field_i,

  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic signed [31:0] value_out_o,
  output logic        status_out_o,
  output logic [7:0]  length_out_o
);

  phase_e phase_q, phase_d;
  num_t   num_q, num_d;

  logic        out_valid_q, out_valid_d;
  logic [31:0] value_q, value_d;
  logic        status_q, status_d;
  logic [7:0]  length_q, length_d;

  logic        in_xfer;
  logic        is_digit;
  logic [3:0]  digit;
  num_t        eff;
  logic        finish;
  logic        accepted;
  logic [MAG_W-1:0] mag_next;
  logic [LEN_W-1:0] consumed_next;

  // The output register can take a new result unless it is full and stalled.
  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_xfer    = in_valid_i & ~in_stall_o;

  assign is_digit = (char_in_i inside {[8'h30:8'h39]});
  assign digit    = char_in_i[3:0];

  // A start byte begins from a cleared accumulator; otherwise continue.
  assign eff = starts_field_i ? NUM_CLEAR : num_q;

  assign mag_next = (eff.magnitude << 3) + (eff.magnitude << 1) + MAG_W'(digit);
  assign consumed_next = (eff.consumed_count == LEN_MAX) ? eff.consumed_count
                                                         : eff.consumed_count + LEN_W'(1);

  assign accepted = ((eff.digit_count != '0) || eff.saw_leading_zero) &&
                    (eff.digit_count <= MAX_DIGITS) && (eff.magnitude <= MAX_MAG);

  always_comb begin
    phase_d = phase_q;
    num_d   = num_q;
    finish  = 1'b0;
    if (in_xfer && (starts_field_i || phase_q != PH_IDLE)) begin
      phase_d = starts_field_i ? PH_SIGN : phase_q;
      num_d   = eff;
      if (starts_field_i && (char_in_i == CHAR_MINUS || char_in_i == CHAR_PLUS)) begin
        num_d.is_negative    = (char_in_i == CHAR_MINUS);
        num_d.consumed_count = LEN_W'(1);
      end else if (is_digit) begin
        if (eff.digit_count == '0 && digit == 4'd0) begin
          num_d.saw_leading_zero = 1'b1;
        end else begin
          if (eff.digit_count < MAX_DIGITS) begin
            num_d.magnitude   = mag_next;
            num_d.digit_count = eff.digit_count + DCNT_W'(1);
          end else begin
            num_d.digit_count = OVER_DIGITS;
          end
          phase_d = PH_DIGITS;
        end
        num_d.consumed_count = consumed_next;
      end else begin
        // Any other byte closes the number and produces one result.
        finish  = 1'b1;
        phase_d = PH_IDLE;
        num_d   = NUM_CLEAR;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q & out_stall_i;
    value_d     = value_q;
    status_d    = status_q;
    length_d    = length_q;
    if (finish) begin
      out_valid_d = 1'b1;
      if (accepted) begin
        value_d  = eff.is_negative ? 32'd0 - eff.magnitude[31:0] : eff.magnitude[31:0];
        status_d = 1'b0;
        length_d = eff.consumed_count;
      end else begin
        value_d  = NA_VALUE;
        status_d = 1'b1;
        length_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      num_q       <= NUM_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      num_q       <= num_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload carries no reset; it is qualified by out_valid_q.
  always_ff @(posedge clk_i) begin
    value_q  <= value_d;
    status_q <= status_d;
    length_q <= length_d;
  end

  assign out_valid_o  = out_valid_q;
  assign value_out_o  = value_q;
  assign status_out_o = status_q;
  assign length_out_o = length_q;

  // A rejected result always carries the NA value and a zero length.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_out_o |-> (value_out_o == NA_VALUE) && (length_out_o == '0))
    else $error("rejected result with payload");

  // An accepted result consumed at least one byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !status_out_o |-> length_out_o != '0)
    else $error("accepted result with zero length");

  // While idle the accumulator stays cleared.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_IDLE |-> num_q == NUM_CLEAR)
    else $error("accumulator not cleared while idle");

  // The digit count never goes past the overflow mark.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    num_q.digit_count <= OVER_DIGITS)
    else $error("digit count out of range");

  // A closing byte always yields a result in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    finish |=> out_valid_o)
    else $error("result lost");

endmodule
